// ===== sv/fjvf_pkg.sv =====
package fjvf_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DataW = 24;
  localparam int unsigned GainW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Default number of fraction bits (Q12.12).
  localparam int unsigned FracBitsDefault = 12;

  // Saturation bounds of a 24-bit signed result.
  localparam logic signed [DataW-1:0] Max24 = 24'sh7FFFFF;
  localparam logic signed [DataW-1:0] Min24 = 24'sh800000;

  // Register reset values.
  localparam logic signed [DataW-1:0] AccUpperRst = 24'sd4096;
  localparam logic signed [DataW-1:0] AccLowerRst = -24'sd4096;
  localparam logic signed [DataW-1:0] JerkUpperRst = 24'sd1229;
  localparam logic signed [DataW-1:0] JerkLowerRst = -24'sd1229;
  localparam logic [GainW-1:0] GainRst = 16'd77;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACC_UPPER  = 3'd0,
    CFG_ACC_LOWER  = 3'd1,
    CFG_JERK_UPPER = 3'd2,
    CFG_JERK_LOWER = 3'd3,
    CFG_GAIN       = 3'd4
  } cfg_idx_e;

  // Input item kinds.
  localparam logic KindStart = 1'b0;
  localparam logic KindPoint = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] acc_upper;
    logic signed [DataW-1:0] acc_lower;
    logic signed [DataW-1:0] jerk_upper;
    logic signed [DataW-1:0] jerk_lower;
    logic [GainW-1:0]        gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT_START,
    ST_DT_WAIT,
    ST_MUL_V,
    ST_VEL,
    ST_HOLD,
    ST_MUL_G,
    ST_LIM,
    ST_JERK_START,
    ST_JERK_WAIT,
    ST_MUL_J,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic {
    DIV_DT,
    DIV_JERK
  } div_sel_e;

  typedef enum logic [1:0] {
    MUL_AV,
    MUL_GAIN,
    MUL_JD
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     load_init;
    logic     div_start;
    div_sel_e div_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     cap_dt;
    logic     cap_nv;
    logic     cap_lim;
    logic     cap_jerk;
    logic     cap_acc;
    logic     commit_vel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dt_zero;
  } sts_t;

endpackage

// ===== sv/forward_jerk_limited_velocity_filter_top.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  kind_i, seg_dist_i, ref_vel_i, init_vel_i,
//                                               init_acc_i
// out       output     out_valid_o / out_ready_i out_vel_o, out_acc_o
// cfg       input      cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
// A point item's processing time is set by the shared two-bit-per-cycle divider, which
// runs for the time step and for the jerk (its width grows with FRAC_BITS, Q12.12 by
// default); with a zero time step the jerk is skipped and the acceleration kept. A start
// item's initial values go to the output in ST_OUT; the input is ready again as they load.
// One item is in work at a time; a new item is accepted while a result waits for
// out_ready_i. Asynchronous active-low reset restores the defaults and zeroes the state.
module forward_jerk_limited_velocity_filter_top #(
  parameter int unsigned FRAC_BITS = fjvf_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fjvf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fjvf_pkg::DataW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [fjvf_pkg::DataW-1:0]        seg_dist_i,
  input  logic signed [fjvf_pkg::DataW-1:0] ref_vel_i,
  input  logic signed [fjvf_pkg::DataW-1:0] init_vel_i,
  input  logic signed [fjvf_pkg::DataW-1:0] init_acc_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fjvf_pkg::DataW-1:0] out_vel_o,
  output logic signed [fjvf_pkg::DataW-1:0] out_acc_o
);

  fjvf_pkg::cfg_t cfg;
  fjvf_pkg::cmd_t cmd;
  fjvf_pkg::sts_t sts;

  // Configuration registers.
  fjvf_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o(cfg)
  );

  // Sequencer for the per-point computation.
  fjvf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .out_valid_o,
    .out_ready_i,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // Arithmetic, state and output registers.
  fjvf_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .sts_o(sts),
    .cfg_i(cfg),
    .seg_dist_i,
    .ref_vel_i,
    .init_vel_i,
    .init_acc_i,
    .out_vel_o,
    .out_acc_o
  );

endmodule

// ===== sv/fjvf_cfg_regs.sv =====
module fjvf_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fjvf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fjvf_pkg::DataW-1:0]          cfg_wdata_i,
  output fjvf_pkg::cfg_t                      cfg_o
);

  fjvf_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fjvf_pkg::CFG_ACC_UPPER:  cfg_d.acc_upper = cfg_wdata_i;
        fjvf_pkg::CFG_ACC_LOWER:  cfg_d.acc_lower = cfg_wdata_i;
        fjvf_pkg::CFG_JERK_UPPER: cfg_d.jerk_upper = cfg_wdata_i;
        fjvf_pkg::CFG_JERK_LOWER: cfg_d.jerk_lower = cfg_wdata_i;
        fjvf_pkg::CFG_GAIN:       cfg_d.gain = cfg_wdata_i[fjvf_pkg::GainW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acc_upper  <= fjvf_pkg::AccUpperRst;
      cfg_q.acc_lower  <= fjvf_pkg::AccLowerRst;
      cfg_q.jerk_upper <= fjvf_pkg::JerkUpperRst;
      cfg_q.jerk_lower <= fjvf_pkg::JerkLowerRst;
      cfg_q.gain       <= fjvf_pkg::GainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/fjvf_div.sv =====
module fjvf_div #(
  parameter int unsigned DIV_W = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DIV_W-1:0]           dividend_i,
  input  logic [fjvf_pkg::DataW-1:0] divisor_i,
  output logic                       done_o,
  output logic [DIV_W-1:0]           quot_o
);

  localparam int unsigned DataW = fjvf_pkg::DataW;
  // Two quotient bits are produced per cycle, so DIV_W must be even.
  localparam int unsigned Steps = DIV_W / 2;
  localparam int unsigned CntW = (Steps > 1) ? $clog2(Steps) : 1;

  logic [DIV_W-1:0] shreg_q, shreg_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dsor_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DataW:0]   step1, step2;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  function automatic logic [DataW:0] div_step(input logic [DataW-1:0] rem,
                                              input logic bit_in,
                                              input logic [DataW-1:0] dsor);
    logic [DataW:0] trial;
    trial = {rem, bit_in};
    if (trial >= {1'b0, dsor}) begin
      div_step = {1'b1, DataW'(trial - {1'b0, dsor})};
    end else begin
      div_step = {1'b0, trial[DataW-1:0]};
    end
  endfunction

  // Two dependent steps per cycle; quotient bits shift in at the bottom.
  always_comb begin
    step1 = div_step(rem_q, shreg_q[DIV_W-1], dsor_q);
    step2 = div_step(step1[DataW-1:0], shreg_q[DIV_W-2], dsor_q);
    shreg_d = shreg_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      shreg_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      shreg_d = {shreg_q[DIV_W-3:0], step1[DataW], step2[DataW]};
      rem_d = step2[DataW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsor_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = shreg_q;

endmodule

// ===== sv/fjvf_datapath.sv =====
module fjvf_datapath #(
  parameter int unsigned FRAC_BITS = fjvf_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fjvf_pkg::cmd_t                    cmd_i,
  output fjvf_pkg::sts_t                    sts_o,
  input  fjvf_pkg::cfg_t                    cfg_i,
  input  logic [fjvf_pkg::DataW-1:0]        seg_dist_i,
  input  logic signed [fjvf_pkg::DataW-1:0] ref_vel_i,
  input  logic signed [fjvf_pkg::DataW-1:0] init_vel_i,
  input  logic signed [fjvf_pkg::DataW-1:0] init_acc_i,
  output logic signed [fjvf_pkg::DataW-1:0] out_vel_o,
  output logic signed [fjvf_pkg::DataW-1:0] out_acc_o
);

  localparam int unsigned DataW = fjvf_pkg::DataW;
  localparam int unsigned MulW = DataW + 1;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned SumW = ProdW + 1;
  // Jerk dividend magnitude reaches 2^(DataW+FRAC_BITS); pad to even width.
  localparam int unsigned DivRaw = DataW + 1 + FRAC_BITS;
  localparam int unsigned DivW = DivRaw + (DivRaw % 2);
  localparam logic signed [DataW-1:0] One = DataW'(64'd1 << FRAC_BITS);

  // Filter state and per-point working registers.
  logic signed [DataW-1:0] vel_q, acc_q;
  logic [DataW-1:0]        ds_q, dt_q;
  logic signed [DataW-1:0] ref_q, nv_q, lim_q, jerk_q;
  logic signed [DataW-1:0] out_vel_q, out_acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    neg_q;

  logic [DivW-1:0]         div_dividend, div_quot;
  logic [DataW-1:0]        div_divisor, vel_div;
  logic                    div_done;
  logic signed [DataW:0]   diff;
  logic [DataW:0]          mag;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [SumW-1:0]  nv_sum, na_sum;
  logic signed [ProdW-1:0] fb, fb_hi, lim_t;
  logic signed [DivW:0]    jerk_full, jerk_hi, jerk_t;
  logic signed [DataW-1:0] nv_new, na_new;

  function automatic logic signed [DataW-1:0] sat24(input logic signed [SumW-1:0] x);
    if (x > SumW'(fjvf_pkg::Max24)) begin
      sat24 = fjvf_pkg::Max24;
    end else if (x < SumW'(fjvf_pkg::Min24)) begin
      sat24 = fjvf_pkg::Min24;
    end else begin
      sat24 = x[DataW-1:0];
    end
  endfunction

  // Divider operand selection: time step first, then jerk magnitude.
  always_comb begin
    vel_div = (vel_q > One) ? vel_q : One;
    diff = $signed({lim_q[DataW-1], lim_q}) - $signed({acc_q[DataW-1], acc_q});
    mag = diff[DataW] ? (DataW + 1)'(-diff) : diff;
    if (cmd_i.div_sel == fjvf_pkg::DIV_DT) begin
      div_dividend = DivW'({ds_q, {FRAC_BITS{1'b0}}});
      div_divisor = vel_div;
    end else begin
      div_dividend = DivW'({mag, {FRAC_BITS{1'b0}}});
      div_divisor = dt_q;
    end
  end

  fjvf_div #(
    .DIV_W(DivW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Shared multiplier operands.
  always_comb begin
    unique case (cmd_i.mul_sel)
      fjvf_pkg::MUL_AV: begin
        mul_a = {acc_q[DataW-1], acc_q};
        mul_b = {1'b0, dt_q};
      end
      fjvf_pkg::MUL_GAIN: begin
        mul_a = {(MulW - fjvf_pkg::GainW)'(0), cfg_i.gain};
        mul_b = $signed({ref_q[DataW-1], ref_q}) - $signed({nv_q[DataW-1], nv_q});
      end
      fjvf_pkg::MUL_JD: begin
        mul_a = {jerk_q[DataW-1], jerk_q};
        mul_b = {1'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Velocity update, feedback limit, jerk limit and acceleration update.
  always_comb begin
    nv_sum = SumW'(vel_q) + SumW'(prod_q >>> FRAC_BITS);
    if (nv_sum < 0) begin
      nv_new = '0;
    end else begin
      nv_new = sat24(nv_sum);
    end

    fb = prod_q >>> 8;
    fb_hi = (fb > ProdW'(cfg_i.acc_upper)) ? ProdW'(cfg_i.acc_upper) : fb;
    lim_t = (fb_hi < ProdW'(cfg_i.acc_lower)) ? ProdW'(cfg_i.acc_lower) : fb_hi;

    jerk_full = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    jerk_hi = (jerk_full > (DivW + 1)'(cfg_i.jerk_upper)) ?
              (DivW + 1)'(cfg_i.jerk_upper) : jerk_full;
    jerk_t = (jerk_hi < (DivW + 1)'(cfg_i.jerk_lower)) ?
             (DivW + 1)'(cfg_i.jerk_lower) : jerk_hi;

    na_sum = SumW'(acc_q) + SumW'(prod_q >>> FRAC_BITS);
    na_new = sat24(na_sum);
  end

  // The filter state resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      acc_q <= '0;
    end else begin
      if (cmd_i.load_init) begin
        vel_q <= init_vel_i;
        acc_q <= init_acc_i;
      end
      if (cmd_i.commit_vel) begin
        vel_q <= nv_q;
      end
      if (cmd_i.cap_acc) begin
        acc_q <= na_new;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ds_q <= seg_dist_i;
      ref_q <= ref_vel_i;
    end
    if (cmd_i.div_start) begin
      neg_q <= diff[DataW];
    end
    if (cmd_i.cap_dt) begin
      dt_q <= div_quot[DataW-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.cap_nv) begin
      nv_q <= nv_new;
    end
    if (cmd_i.cap_lim) begin
      lim_q <= lim_t[DataW-1:0];
    end
    if (cmd_i.cap_jerk) begin
      jerk_q <= jerk_t[DataW-1:0];
    end
    if (cmd_i.load_out) begin
      out_vel_q <= vel_q;
      out_acc_q <= acc_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.dt_zero = (dt_q == '0);
  assign out_vel_o = out_vel_q;
  assign out_acc_o = out_acc_q;

endmodule

// ===== sv/fjvf_ctrl.sv =====
module fjvf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fjvf_pkg::sts_t sts_i,
  output fjvf_pkg::cmd_t cmd_o
);

  fjvf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer, slot_free;

  assign in_xfer = in_valid_i && (state_q == fjvf_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fjvf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (kind_i == fjvf_pkg::KindStart) ? fjvf_pkg::ST_OUT
                                                   : fjvf_pkg::ST_DT_START;
        end
      end
      fjvf_pkg::ST_DT_START:   state_d = fjvf_pkg::ST_DT_WAIT;
      fjvf_pkg::ST_DT_WAIT: begin
        if (sts_i.div_done) begin
          state_d = fjvf_pkg::ST_MUL_V;
        end
      end
      fjvf_pkg::ST_MUL_V:      state_d = fjvf_pkg::ST_VEL;
      fjvf_pkg::ST_VEL: begin
        state_d = sts_i.dt_zero ? fjvf_pkg::ST_HOLD : fjvf_pkg::ST_MUL_G;
      end
      fjvf_pkg::ST_HOLD:       state_d = fjvf_pkg::ST_OUT;
      fjvf_pkg::ST_MUL_G:      state_d = fjvf_pkg::ST_LIM;
      fjvf_pkg::ST_LIM:        state_d = fjvf_pkg::ST_JERK_START;
      fjvf_pkg::ST_JERK_START: state_d = fjvf_pkg::ST_JERK_WAIT;
      fjvf_pkg::ST_JERK_WAIT: begin
        if (sts_i.div_done) begin
          state_d = fjvf_pkg::ST_MUL_J;
        end
      end
      fjvf_pkg::ST_MUL_J:      state_d = fjvf_pkg::ST_ACC;
      fjvf_pkg::ST_ACC:        state_d = fjvf_pkg::ST_OUT;
      fjvf_pkg::ST_OUT: begin
        if (slot_free) begin
          state_d = fjvf_pkg::ST_IDLE;
        end
      end
      default:                 state_d = fjvf_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = fjvf_pkg::DIV_DT;
    cmd_o.mul_sel = fjvf_pkg::MUL_AV;
    unique case (state_q)
      fjvf_pkg::ST_IDLE: begin
        cmd_o.load_in = in_xfer;
        cmd_o.load_init = in_xfer && (kind_i == fjvf_pkg::KindStart);
      end
      fjvf_pkg::ST_DT_START: begin
        cmd_o.div_start = 1'b1;
      end
      fjvf_pkg::ST_DT_WAIT: begin
        cmd_o.cap_dt = sts_i.div_done;
      end
      fjvf_pkg::ST_MUL_V: begin
        cmd_o.mul_en = 1'b1;
      end
      fjvf_pkg::ST_VEL: begin
        cmd_o.cap_nv = 1'b1;
      end
      fjvf_pkg::ST_HOLD: begin
        cmd_o.commit_vel = 1'b1;
      end
      fjvf_pkg::ST_MUL_G: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = fjvf_pkg::MUL_GAIN;
      end
      fjvf_pkg::ST_LIM: begin
        cmd_o.cap_lim = 1'b1;
      end
      fjvf_pkg::ST_JERK_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = fjvf_pkg::DIV_JERK;
      end
      fjvf_pkg::ST_JERK_WAIT: begin
        cmd_o.div_sel = fjvf_pkg::DIV_JERK;
        cmd_o.cap_jerk = sts_i.div_done;
      end
      fjvf_pkg::ST_MUL_J: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = fjvf_pkg::MUL_JD;
      end
      fjvf_pkg::ST_ACC: begin
        cmd_o.cap_acc = 1'b1;
        cmd_o.commit_vel = 1'b1;
      end
      fjvf_pkg::ST_OUT: begin
        cmd_o.load_out = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output register valid: set when a result is loaded, cleared on transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == fjvf_pkg::ST_OUT && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fjvf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == fjvf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/fjvf_checker.sv =====
module fjvf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       kind_i,
  input logic [fjvf_pkg::DataW-1:0] init_vel_i,
  input logic [fjvf_pkg::DataW-1:0] init_acc_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [fjvf_pkg::DataW-1:0] out_vel_o,
  input logic [fjvf_pkg::DataW-1:0] out_acc_o
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_vel_o) && $stable(out_acc_o))
    else $error("result changed or dropped while stalled");

  // Only one item is in work: ready drops after every input transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // A start item into an empty output register is echoed once it has passed through ST_OUT.
  a_start_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == fjvf_pkg::KindStart) && !out_valid_o
      |=> ##1 out_valid_o && (out_vel_o == $past(init_vel_i, 2)) &&
          (out_acc_o == $past(init_acc_i, 2)))
    else $error("start item not echoed");

  // A new result appears together with the block returning to ready.
  a_result_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while still busy");

  // A point item still holds the block busy once the divider has been started.
  a_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == fjvf_pkg::KindPoint) |=> ##1 !in_ready_o)
    else $error("point item finished too early");

endmodule

bind forward_jerk_limited_velocity_filter_top fjvf_checker u_fjvf_checker (.*);
